### hw/rtl/dmtv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmtv_pkg: shared types and constants of the display mode timing validator
// Beat structs, reason codes, register indexes and divider constants.
// ----------------------------------------------------------------------------
package dmtv_pkg;

  localparam int unsigned PipeDepth = 6;

  typedef enum logic [2:0] {
    RSN_OK          = 3'd0,
    RSN_HSYNC_ORDER = 3'd1,
    RSN_HTOTAL      = 3'd2,
    RSN_VSYNC_ORDER = 3'd3,
    RSN_VTOTAL      = 3'd4,
    RSN_REFRESH     = 3'd5,
    RSN_LINE_RATE   = 3'd6,
    RSN_FRAME_RATE  = 3'd7
  } reason_t;

  typedef enum logic [2:0] {
    REG_RANGE_EN = 3'd0,
    REG_LINE_MIN = 3'd1,
    REG_LINE_MAX = 3'd2,
    REG_FRAME_MIN = 3'd3,
    REG_FRAME_MAX = 3'd4
  } reg_index_t;

  localparam logic [29:0] RECIP_125  = 30'd549755813; // floor(2^36 / 125)
  localparam logic [9:0]  SCALE_KHZ  = 10'd1000;
  localparam logic [5:0]  REFRESH_LO = 6'd30;
  localparam logic [7:0]  REFRESH_HI = 8'd251;        // one above 250 Hz

  typedef struct packed {
    logic [19:0] pixel_clock_khz;
    logic [15:0] h_active;
    logic [15:0] h_sync_begin;
    logic [15:0] h_sync_finish;
    logic [15:0] h_period;
    logic [15:0] v_active;
    logic [15:0] v_sync_begin;
    logic [15:0] v_sync_finish;
    logic [15:0] v_period;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] reject_reason;
  } result_t;

  // control beat handed from cell to cell
  typedef struct packed {
    logic    valid;
    reason_t reason;
  } beat_t;

endpackage

### hw/rtl/display_mode_timing_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_mode_timing_validator: modeline range check
// Six-cell chain checking sync order, totals, refresh, line and frame rate.
// ----------------------------------------------------------------------------
// A modeline is taken on every cycle (busy stays low) and its verdict appears
// on result with result_valid once it has passed the six registered check
// cells, one result per modeline, in order. The cells are, in order: product
// terms, constant scaling, the refresh compare, the divide-by-1000
// correction, the frame bound products and the final frame compare. Results
// cannot be held off; capture them in the cycle they are shown. Write the
// registers only while no modeline is in flight.
module display_mode_timing_validator (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  dmtv_pkg::item_t   item,
  output logic              result_valid,
  output dmtv_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import dmtv_pkg::*;

  logic       range_en;
  logic [7:0] line_min, line_max, frame_min, frame_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_en  <= 1'b0;
      line_min  <= 8'd0;
      line_max  <= 8'd255;
      frame_min <= 8'd0;
      frame_max <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_EN:  range_en  <= cfg_data[0];
        REG_LINE_MIN:  line_min  <= cfg_data;
        REG_LINE_MAX:  line_max  <= cfg_data;
        REG_FRAME_MIN: frame_min <= cfg_data;
        REG_FRAME_MAX: frame_max <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  beat_t   beat [PipeDepth+1];
  logic    fail [PipeDepth];
  reason_t code [PipeDepth];

  // stage 0: order checks and first products
  reason_t     early;
  logic [31:0] area0;
  logic [29:0] p1000_0;
  logic [8:0]  lhi_f, llo_f;
  logic [24:0] lhi0;
  logic [23:0] llo0;

  always_comb begin
    if (item.h_sync_begin > item.h_sync_finish)   early = RSN_HSYNC_ORDER;
    else if (item.h_period < item.h_active)       early = RSN_HTOTAL;
    else if (item.v_sync_begin > item.v_sync_finish) early = RSN_VSYNC_ORDER;
    else if (item.v_period < item.v_active)       early = RSN_VTOTAL;
    else                                          early = RSN_OK;
  end

  assign area0   = item.h_period * item.v_period;
  assign p1000_0 = 30'(item.pixel_clock_khz) * 30'(SCALE_KHZ);
  assign lhi_f   = 9'(line_max) + 9'd2;
  assign llo_f   = (line_min == 8'd0) ? 9'd0 : 9'(line_min) - 9'd1;
  assign lhi0    = 25'(lhi_f) * 25'(item.h_period);
  assign llo0    = 24'(llo_f[7:0]) * 24'(item.h_period);

  assign beat[0].valid  = start & ~busy;
  assign beat[0].reason = RSN_OK;
  assign fail[0] = (early != RSN_OK);
  assign code[0] = early;

  logic [19:0] pclk1;
  logic [31:0] area1;
  logic [29:0] p1000_1;
  logic [24:0] lhi1;
  logic [23:0] llo1;
  always_ff @(posedge clk) begin
    pclk1 <= item.pixel_clock_khz;
    area1 <= area0;
    p1000_1 <= p1000_0;
    lhi1 <= lhi0;
    llo1 <= llo0;
  end

  // stage 1: refresh bounds, reciprocal estimate, line rate verdict
  logic [36:0] rlo1;
  logic [39:0] rhi1;
  logic [58:0] xm1;
  logic        lfail1;
  assign rlo1   = 37'(area1) * 37'(REFRESH_LO);
  assign rhi1   = 40'(area1) * 40'(REFRESH_HI);
  assign xm1    = 59'(area1[31:3]) * 59'(RECIP_125);
  assign lfail1 = range_en &&
                  ((25'(pclk1) >= lhi1) || (24'(pclk1) < llo1));
  assign fail[1] = 1'b0;
  assign code[1] = RSN_OK;

  logic [19:0] pclk2;
  logic [31:0] area2;
  logic [29:0] p1000_2;
  logic [36:0] rlo2;
  logic [39:0] rhi2;
  logic [21:0] q2;
  logic        lfail2;
  always_ff @(posedge clk) begin
    pclk2 <= pclk1;
    area2 <= area1;
    p1000_2 <= p1000_1;
    rlo2 <= rlo1;
    rhi2 <= rhi1;
    q2 <= xm1[57:36];
    lfail2 <= lfail1;
  end

  // stage 2: refresh verdict
  assign fail[2] = (area2 == 32'd0) || (37'(p1000_2) < rlo2) ||
                   (40'(p1000_2) >= rhi2);
  assign code[2] = RSN_REFRESH;

  logic [19:0] pclk3;
  logic [28:0] x3;
  logic [21:0] q3;
  logic        lfail3;
  always_ff @(posedge clk) begin
    pclk3 <= pclk2;
    x3 <= area2[31:3];
    q3 <= q2;
    lfail3 <= lfail2;
  end

  // stage 3: correct the quotient estimate, line verdict
  logic [28:0] rem3;
  logic [21:0] fd3;
  assign rem3 = x3 - 29'(q3) * 29'd125;
  assign fd3  = (rem3 >= 29'd125) ? q3 + 22'd1 : q3;
  assign fail[3] = lfail3;
  assign code[3] = RSN_LINE_RATE;

  logic [19:0] pclk4;
  logic [21:0] fd4;
  always_ff @(posedge clk) begin
    pclk4 <= pclk3;
    fd4 <= fd3;
  end

  // stage 4: frame bound products, zero divisor
  logic [8:0]  fhi_f, flo_f;
  logic [30:0] fhi4;
  logic [29:0] flo4;
  assign fhi_f = 9'(frame_max) + 9'd2;
  assign flo_f = (frame_min == 8'd0) ? 9'd0 : 9'(frame_min) - 9'd1;
  assign fhi4  = 31'(fhi_f) * 31'(fd4);
  assign flo4  = 30'(flo_f[7:0]) * 30'(fd4);
  assign fail[4] = range_en && (fd4 == 22'd0);
  assign code[4] = RSN_FRAME_RATE;

  logic [19:0] pclk5;
  logic [30:0] fhi5;
  logic [29:0] flo5;
  always_ff @(posedge clk) begin
    pclk5 <= pclk4;
    fhi5 <= fhi4;
    flo5 <= flo4;
  end

  // stage 5: frame verdict
  assign fail[5] = range_en && ((31'(pclk5) >= fhi5) || (30'(pclk5) < flo5));
  assign code[5] = RSN_FRAME_RATE;

  for (genvar i = 0; i < PipeDepth; i++) begin : g_cell
    dmtv_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .beat_in (beat[i]),
      .fail    (fail[i]),
      .code    (code[i]),
      .beat_out(beat[i+1])
    );
  end

  assign result_valid         = beat[PipeDepth].valid;
  assign result.reject_reason = beat[PipeDepth].reason;
  assign result.accepted      = (beat[PipeDepth].reason == RSN_OK);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##6 result_valid)
    else $error("modeline verdict missing");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, 6))
    else $error("verdict without modeline");

  a_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.accepted == (result.reject_reason == RSN_OK)))
    else $error("accept flag disagrees with reason");

endmodule

### hw/rtl/dmtv_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmtv_cell: one check cell of the validator chain
// Registers the beat and records its own reason if no earlier cell failed.
// ----------------------------------------------------------------------------
module dmtv_cell (
  input  logic           clk,
  input  logic           rst,
  input  dmtv_pkg::beat_t beat_in,
  input  logic           fail,
  input  dmtv_pkg::reason_t code,
  output dmtv_pkg::beat_t beat_out
);
  import dmtv_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out.valid <= 1'b0;
    end else begin
      beat_out.valid <= beat_in.valid;
    end
    // first failing check keeps its reason
    if (beat_in.reason == RSN_OK && fail) begin
      beat_out.reason <= code;
    end else begin
      beat_out.reason <= beat_in.reason;
    end
  end

endmodule

### bench/display_mode_timing_validator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_mode_timing_validator_tb: self-checking bench for the mode checker
// Drives directed and random modelines through several register settings,
// predicts each verdict and compares it with the strobed result in order.
// ----------------------------------------------------------------------------
module display_mode_timing_validator_tb;
  import dmtv_pkg::*;

  class verdict_board;
    result_t pending[$];
    int      errors;
    bit      rc_en;
    int      line_lo, line_hi, frame_lo, frame_hi;

    function new();
      errors = 0;
      rc_en = 0;
      line_lo = 0; line_hi = 255; frame_lo = 0; frame_hi = 255;
    endfunction

    function void set_reg(reg_index_t idx, logic [7:0] val);
      case (idx)
        REG_RANGE_EN:  rc_en = val[0];
        REG_LINE_MIN:  line_lo = int'(val);
        REG_LINE_MAX:  line_hi = int'(val);
        REG_FRAME_MIN: frame_lo = int'(val);
        REG_FRAME_MAX: frame_hi = int'(val);
        default: ;
      endcase
    endfunction

    function bit out_of_band(longint unsigned rate, int lo, int hi);
      longint unsigned lb;
      lb = (lo == 0) ? 64'd0 : 64'(lo - 1);
      return (rate > 64'(hi + 1)) || (rate < lb);
    endfunction

    function reason_t judge(item_t m);
      longint unsigned area, refresh, frame_div;
      if (m.h_sync_begin > m.h_sync_finish) return RSN_HSYNC_ORDER;
      if (m.h_period < m.h_active) return RSN_HTOTAL;
      if (m.v_sync_begin > m.v_sync_finish) return RSN_VSYNC_ORDER;
      if (m.v_period < m.v_active) return RSN_VTOTAL;
      area = longint'(m.h_period) * longint'(m.v_period);
      if (area == 0) return RSN_REFRESH;
      refresh = (longint'(m.pixel_clock_khz) * 1000) / area;
      if (refresh < 30 || refresh > 250) return RSN_REFRESH;
      if (rc_en) begin
        if (out_of_band(longint'(m.pixel_clock_khz) / m.h_period, line_lo, line_hi))
          return RSN_LINE_RATE;
        frame_div = area / 1000;
        if (frame_div == 0) return RSN_FRAME_RATE;
        if (out_of_band(longint'(m.pixel_clock_khz) / frame_div, frame_lo, frame_hi))
          return RSN_FRAME_RATE;
      end
      return RSN_OK;
    endfunction

    function void note_mode(item_t m);
      result_t r;
      r.reject_reason = judge(m);
      r.accepted = (r.reject_reason == RSN_OK);
      pending.push_back(r);
    endfunction

    function void check_verdict(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result accepted=%0d reason=%0d", got.accepted, got.reject_reason);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
        errors++;
      end
      if (got.reject_reason !== want.reject_reason) begin
        $error("reject_reason: expected %0d, got %0d", want.reject_reason, got.reject_reason);
        errors++;
      end
    endfunction
  endclass

  logic    clk = 0;
  logic    rst = 1;
  logic    start = 0;
  logic    busy;
  item_t   item = '0;
  logic    result_valid;
  result_t result;
  logic    cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  verdict_board board = new();
  int cycles = 0;
  int idle_pct = 0;
  localparam int CycleLimit = 200000;

  always #5 clk = ~clk;

  display_mode_timing_validator dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && start && !busy) board.note_mode(item);
    if (!rst && result_valid) board.check_verdict(result);
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(reg_index_t idx, logic [7:0] val);
    @(negedge clk);
    start <= 0;
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // hold until every verdict is in, plus pipeline latency
  task automatic drain();
    @(negedge clk);
    start <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (PipeDepth + 4) @(negedge clk);
  endtask

  task automatic send_mode(item_t m);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    item <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // plausible modeline with random content
  function automatic item_t sane_mode();
    item_t m;
    m.h_active = 16'($urandom_range(4000, 1));
    m.h_sync_begin = 16'(m.h_active + $urandom_range(200));
    m.h_sync_finish = 16'(m.h_sync_begin + $urandom_range(300));
    m.h_period = 16'(m.h_sync_finish + $urandom_range(300));
    m.v_active = 16'($urandom_range(2500, 1));
    m.v_sync_begin = 16'(m.v_active + $urandom_range(20));
    m.v_sync_finish = 16'(m.v_sync_begin + $urandom_range(20));
    m.v_period = 16'(m.v_sync_finish + $urandom_range(60));
    m.pixel_clock_khz =
      20'((longint'(m.h_period) * m.v_period * $urandom_range(260, 20)) / 1000);
    if ($urandom_range(3) == 0) m.pixel_clock_khz = 20'($urandom);
    return m;
  endfunction

  function automatic item_t rough_mode();
    item_t m;
    m = sane_mode();
    case ($urandom_range(5))
      0: m = item_t'({$urandom, $urandom, $urandom, $urandom, 20'($urandom)});
      1: m.h_sync_begin = 16'($urandom);
      2: m.h_period = 16'($urandom);
      3: m.v_sync_finish = 16'($urandom);
      4: m.v_period = 16'($urandom);
      default: m.pixel_clock_khz = 20'($urandom);
    endcase
    return m;
  endfunction

  task automatic random_modes(int n);
    repeat (n) send_mode(($urandom_range(9) < 7) ? sane_mode() : rough_mode());
  endtask

  task automatic directed_modes();
    item_t m;
    m = '0; send_mode(m);
    m = '1; send_mode(m);
    m = sane_mode(); m.h_sync_begin = 16'(m.h_sync_finish + 16'd1); send_mode(m);
    m = sane_mode(); m.h_period = 16'(m.h_active - 16'd1); send_mode(m);
    m = sane_mode(); m.v_sync_begin = 16'(m.v_sync_finish + 16'd1); send_mode(m);
    m = sane_mode(); m.v_period = 16'(m.v_active - 16'd1); send_mode(m);
    m = sane_mode(); m.h_active = 16'd0; m.h_period = 16'd0; send_mode(m);
    // refresh just at and just below 30 Hz, then just at and just above 250 Hz
    m = '0; m.h_period = 16'd1000; m.v_period = 16'd1000;
    m.pixel_clock_khz = 20'd30000; send_mode(m);
    m.pixel_clock_khz = 20'd29999; send_mode(m);
    m.pixel_clock_khz = 20'd250999; send_mode(m);
    m.pixel_clock_khz = 20'd251000; send_mode(m);
    // tiny area: frame divisor zero
    m = '0; m.h_period = 16'd10; m.v_period = 16'd10; m.pixel_clock_khz = 20'd10;
    send_mode(m);
    m = '0; m.h_period = 16'hFFFF; m.v_period = 16'hFFFF;
    m.pixel_clock_khz = 20'hFFFFF; send_mode(m);
    repeat (8) send_mode(sane_mode());
  endtask

  task automatic phase(int n);
    write_reg(REG_RANGE_EN, 8'($urandom_range(1)));
    write_reg(REG_LINE_MIN, 8'($urandom_range(120)));
    write_reg(REG_LINE_MAX, 8'($urandom_range(255, 40)));
    write_reg(REG_FRAME_MIN, 8'($urandom_range(90)));
    write_reg(REG_FRAME_MAX, 8'($urandom_range(255, 40)));
    random_modes(n);
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    directed_modes();
    drain();
    write_reg(REG_RANGE_EN, 8'd1);
    directed_modes();
    drain();
    write_reg(REG_LINE_MIN, 8'd0); write_reg(REG_LINE_MAX, 8'd0);
    write_reg(REG_FRAME_MIN, 8'd0); write_reg(REG_FRAME_MAX, 8'd0);
    random_modes(40);
    drain();
    write_reg(REG_LINE_MIN, 8'd255); write_reg(REG_LINE_MAX, 8'd255);
    write_reg(REG_FRAME_MIN, 8'd255); write_reg(REG_FRAME_MAX, 8'd255);
    random_modes(40);
    drain();
    write_reg(REG_LINE_MIN, 8'd1); write_reg(REG_FRAME_MIN, 8'd1);
    write_reg(REG_LINE_MAX, 8'd255); write_reg(REG_FRAME_MAX, 8'd255);
    random_modes(40);
    drain();
    idle_pct = 21;
    phase(150); phase(100);
    idle_pct = 50;
    phase(150); phase(100);
    idle_pct = 0;
    phase(120); phase(80);
    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
